### hw/rtl/tcgw_pkg.sv
// Shared types and constants for the text console glyph writer.
package tcgw_pkg;

   // Fixed field widths
   localparam int ACTION_W = 1;
   localparam int GADDR_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 32;
   localparam int IDX_W    = 24;
   localparam int DIM_W    = 13;
   localparam int COL_W    = 12;
   localparam int ROW_W    = 13;
   localparam int CSR_IDX_W = 2;

   // Glyph geometry
   localparam int GLYPH_WIDTH       = 8;
   localparam int GLYPH_ROWS_DEF    = 16;
   localparam int GLYPH_COUNT_DEF   = 256;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // Register reset values
   localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd1024;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd768;
   localparam logic [DIM_W-1:0]   STRIDE_RST = 13'd1024;
   localparam logic [COLOR_W-1:0] CLEAR_RST  = 32'd0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD  = 1'b0,
      ACT_PRINT = 1'b1
   } action_type;

   typedef enum logic {
      KIND_ROW    = 1'b0,
      KIND_SCROLL = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_STRIDE = 2'd2,
      CSR_CLEAR  = 2'd3
   } csr_index_type;

endpackage

### hw/rtl/tcgw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcgw_ram #(
   parameter  int DATA_W = 8,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port, read port returns the old word on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/text_console_glyph_writer_core.sv
// Path: a print's request is registered in the sequencer, then the read stage, then the output
//   register, which drives rsp_valid; a full stage further on can stall any of these steps.
// Throughput: one result per cycle while rsp_ready holds; a print yields one row beat per glyph
//   row, since each glyph row is one read of the single glyph RAM port, plus a scroll beat first
//   when needed; loads and newlines that need no scroll yield no result.
// Reset: clears cursor, pipeline valids and registers to defaults; the glyph RAM is not
//   cleared and holds garbage until loaded.
module text_console_glyph_writer_core import tcgw_pkg::*; #(
   parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [GADDR_W-1:0]   req_glyph_addr,
   input  logic [BYTE_W-1:0]    req_glyph_byte,
   input  logic [CHAR_W-1:0]    req_character,
   input  logic [COLOR_W-1:0]   req_ink_color,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [IDX_W-1:0]     rsp_pixel_index,
   output logic [BYTE_W-1:0]    rsp_row_mask,
   output logic [COLOR_W-1:0]   rsp_out_color,
   output logic                 rsp_last,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata
);

   localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(GLYPH_ROWS);
   localparam int Y_W    = ROW_W + 1;
   localparam int PROD_W = Y_W + DIM_W;

   // Configuration registers
   logic [DIM_W-1:0]   width_ff, height_ff, stride_ff;
   logic [COLOR_W-1:0] clear_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         stride_ff <= STRIDE_RST;
         clear_ff  <= CLEAR_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_STRIDE: stride_ff <= csr_wdata[DIM_W-1:0];
            CSR_CLEAR:  clear_ff  <= csr_wdata;
         endcase
      end
   end

   // Pipeline control
   logic              s1_busy_ff, s1_busy_in;
   logic              s1_scroll_ff, s1_scroll_in;
   logic              s1_draw_ff, s1_draw_in;
   logic [CNT_W-1:0]  s1_cnt_ff, s1_cnt_in;
   logic [Y_W-1:0]    s1_y_ff, s1_y_in;
   logic [COL_W-1:0]  s1_col_ff, s1_col_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [COLOR_W-1:0] s1_ink_ff, s1_ink_in;

   logic              s2_valid_ff, s2_valid_in;
   logic              s2_kind_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [COLOR_W-1:0] s2_color_ff;
   logic              s2_last_ff;

   logic              s3_valid_ff, s3_valid_in;
   logic              s3_kind_ff;
   logic [IDX_W-1:0]  s3_idx_ff;
   logic [BYTE_W-1:0] s3_mask_ff;
   logic [COLOR_W-1:0] s3_color_ff;
   logic              s3_last_ff;

   logic s1_adv, s1_final, s2_adv;
   logic req_fire, load_fire, print_fire;

   assign s2_adv   = s2_valid_ff && (!s3_valid_ff || rsp_ready);
   assign s1_adv   = s1_busy_ff && (!s2_valid_ff || s2_adv);
   assign s1_final = s1_scroll_ff ? !s1_draw_ff : (s1_cnt_ff == CNT_W'(GLYPH_ROWS - 1));

   assign req_ready  = !s1_busy_ff || (s1_adv && s1_final);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (action_type'(req_action) == ACT_LOAD);
   assign print_fire = req_fire && (action_type'(req_action) == ACT_PRINT);

   // Cursor and per-print decisions
   logic [COL_W-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0] cursor_row_ff, cursor_row_in;
   logic             scroll_need, is_newline, wrap;
   logic [ROW_W-1:0] row_after;
   logic [COL_W-1:0] col_step;
   logic [9:0]       glyph_raw, glyph_sel;

   always_comb begin
      is_newline  = (req_character == NEWLINE_CODE);
      scroll_need = ({1'b0, cursor_row_ff} + Y_W'(GLYPH_ROWS)) >= {1'b0, height_ff};
      if (!scroll_need) begin
         row_after = cursor_row_ff;
      end else if (cursor_row_ff >= ROW_W'(GLYPH_ROWS)) begin
         row_after = cursor_row_ff - ROW_W'(GLYPH_ROWS);
      end else begin
         row_after = '0;
      end
      col_step = cursor_col_ff + COL_W'(GLYPH_WIDTH);
      wrap = (({2'b00, col_step} + 14'(GLYPH_WIDTH + 1)) > {1'b0, width_ff}) || is_newline;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (print_fire) begin
         cursor_col_in = wrap ? '0 : col_step;
         cursor_row_in = wrap ? (row_after + ROW_W'(GLYPH_ROWS)) : row_after;
      end
      // fold the code into the glyph range
      glyph_raw = {2'b00, req_character};
      glyph_sel = (glyph_raw >= 10'(GLYPH_COUNT)) ? (glyph_raw - 10'(GLYPH_COUNT)) : glyph_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   // Beat sequencer: optional scroll beat, then, unless the character is a newline, one beat per glyph row
   always_comb begin
      s1_busy_in   = s1_busy_ff;
      s1_scroll_in = s1_scroll_ff;
      s1_draw_in   = s1_draw_ff;
      s1_cnt_in    = s1_cnt_ff;
      s1_y_in      = s1_y_ff;
      s1_col_in    = s1_col_ff;
      s1_addr_in   = s1_addr_ff;
      s1_ink_in    = s1_ink_ff;
      priority if (print_fire) begin
         s1_busy_in   = scroll_need || !is_newline;
         s1_scroll_in = scroll_need;
         s1_draw_in   = !is_newline;
         s1_cnt_in    = '0;
         s1_y_in      = {1'b0, row_after};
         s1_col_in    = cursor_col_ff;
         s1_addr_in   = ADDR_W'(glyph_sel * GLYPH_ROWS);
         s1_ink_in    = req_ink_color;
      end else if (s1_adv) begin
         if (s1_final) begin
            s1_busy_in = 1'b0;
         end
         if (s1_scroll_ff) begin
            s1_scroll_in = 1'b0;
         end else begin
            s1_cnt_in  = s1_cnt_ff + CNT_W'(1);
            s1_y_in    = s1_y_ff + Y_W'(1);
            s1_addr_in = s1_addr_ff + ADDR_W'(1);
         end
      end else begin
         // hold the sequencer while idle or stalled
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_busy_ff   <= 1'b0;
         s1_scroll_ff <= 1'b0;
         s1_draw_ff   <= 1'b0;
         s1_cnt_ff    <= '0;
      end else begin
         s1_busy_ff   <= s1_busy_in;
         s1_scroll_ff <= s1_scroll_in;
         s1_draw_ff   <= s1_draw_in;
         s1_cnt_ff    <= s1_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_y_ff    <= s1_y_in;
      s1_col_ff  <= s1_col_in;
      s1_addr_ff <= s1_addr_in;
      s1_ink_ff  <= s1_ink_in;
   end

   // Glyph store
   logic              ram_wr_en, ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;

   assign ram_wr_en = load_fire && ({20'd0, req_glyph_addr} < 32'(DEPTH));
   assign ram_rd_en = s1_adv && !s1_scroll_ff;

   tcgw_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_glyph_addr)),
      .wr_data (req_glyph_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (s1_addr_ff),
      .rd_data (ram_rd_data)
   );

   // Row address: y * stride + x, kept to the index width
   logic [PROD_W-1:0] row_prod;
   logic [IDX_W-1:0]  row_idx;

   always_comb begin
      row_prod = {{DIM_W{1'b0}}, s1_y_ff} * {{Y_W{1'b0}}, stride_ff};
      row_idx  = row_prod[IDX_W-1:0] + IDX_W'(s1_col_ff);
   end

   // Read stage, aligned with the RAM read data
   assign s2_valid_in = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_kind_ff  <= s1_scroll_ff ? KIND_SCROLL : KIND_ROW;
         s2_idx_ff   <= s1_scroll_ff ? '0 : row_idx;
         s2_color_ff <= s1_scroll_ff ? clear_ff : s1_ink_ff;
         s2_last_ff  <= s1_final;
      end
   end

   // Output register
   assign s3_valid_in = s2_adv ? 1'b1 : (rsp_ready ? 1'b0 : s3_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_idx_ff   <= s2_idx_ff;
         s3_mask_ff  <= (s2_kind_ff == KIND_SCROLL) ? '0 : ram_rd_data;
         s3_color_ff <= s2_color_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_kind        = s3_kind_ff;
   assign rsp_pixel_index = s3_idx_ff;
   assign rsp_row_mask    = s3_mask_ff;
   assign rsp_out_color   = s3_color_ff;
   assign rsp_last        = s3_last_ff;

   // Checks
   a_scroll_first : assert property (@(posedge clock) disable iff (reset)
      s1_busy_ff && s1_scroll_ff |-> s1_cnt_ff == '0)
      else $error("scroll beat pending after glyph rows started");

   a_scroll_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SCROLL |-> rsp_pixel_index == '0 && rsp_row_mask == '0)
      else $error("scroll result carries index or mask");

   a_col_aligned : assert property (@(posedge clock) disable iff (reset)
      cursor_col_ff[2:0] == 3'd0)
      else $error("cursor column off the glyph grid");

   a_read_draw : assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> s1_busy_ff && s1_draw_ff)
      else $error("glyph read outside a drawing beat");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_final && !req_fire |=> !s1_busy_ff)
      else $error("sequencer busy after its final beat");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the text console glyph writer core.
`timescale 1ns / 1ps

module tb_top;
   import tcgw_pkg::*;

   localparam int STORE_DEPTH   = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF;
   localparam int PHASES        = 7;
   localparam int PRESSURE_PH   = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 16;
   localparam int SETTLE_CAP    = 100000;

   typedef struct packed {
      action_type          action;
      logic [GADDR_W-1:0]  glyph_addr;
      logic [BYTE_W-1:0]   glyph_byte;
      logic [CHAR_W-1:0]   character;
      logic [COLOR_W-1:0]  ink_color;
   } console_req_t;

   typedef struct packed {
      kind_type            kind;
      logic [IDX_W-1:0]    pixel_index;
      logic [BYTE_W-1:0]   row_mask;
      logic [COLOR_W-1:0]  out_color;
      logic                last;
   } pixel_op_t;

   // DUT ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action;
   logic [GADDR_W-1:0]   req_glyph_addr;
   logic [BYTE_W-1:0]    req_glyph_byte;
   logic [CHAR_W-1:0]    req_character;
   logic [COLOR_W-1:0]   req_ink_color;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_kind;
   logic [IDX_W-1:0]     rsp_pixel_index;
   logic [BYTE_W-1:0]    rsp_row_mask;
   logic [COLOR_W-1:0]   rsp_out_color;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]   csr_wdata = '0;

   console_req_t req_payload = '0;

   assign req_action     = req_payload.action;
   assign req_glyph_addr = req_payload.glyph_addr;
   assign req_glyph_byte = req_payload.glyph_byte;
   assign req_character  = req_payload.character;
   assign req_ink_color  = req_payload.ink_color;

   text_console_glyph_writer_core dut (.*);

   always #5 clock = ~clock;

   // Stimulus and scoreboard storage
   console_req_t req_backlog[$];
   pixel_op_t    due_pixel_ops[$];
   int           mismatch_count = 0;

   // Predictor state: console registers, cursor and glyph store copy
   logic [DIM_W-1:0]   scr_width  = WIDTH_RST;
   logic [DIM_W-1:0]   scr_height = HEIGHT_RST;
   logic [DIM_W-1:0]   scr_stride = STRIDE_RST;
   logic [COLOR_W-1:0] clr_color  = CLEAR_RST;
   logic [COL_W-1:0]   cur_col = '0;
   logic [ROW_W-1:0]   cur_row = '0;
   logic [BYTE_W-1:0]  font_copy [STORE_DEPTH];

   // Generator bookkeeping: which glyph rows are written, which chars are printable
   bit                 row_written [STORE_DEPTH];
   bit                 char_usable [GLYPH_COUNT_DEF];
   logic [CHAR_W-1:0]  usable_chars[$];

   // Handshake bookkeeping
   bit req_took = 1'b0;
   bit rsp_took = 1'b0;
   bit req_eager = 1'b0;
   bit rsp_eager = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   bit rsp_hold = 1'b0;
   bit backpressure_go = 1'b0;

   task automatic flag_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Compute the pixel ops one accepted request causes and queue them
   task automatic render_request(console_req_t rq);
      pixel_op_t        batch[$];
      pixel_op_t        one;
      longint unsigned  span;
      int               r;
      if (rq.action == ACT_LOAD) begin
         font_copy[rq.glyph_addr] = rq.glyph_byte;
      end else begin
         // scroll first when the next text line would pass the bottom edge
         if (32'(cur_row) + GLYPH_ROWS_DEF >= 32'(scr_height)) begin
            one = '0;
            one.kind = KIND_SCROLL;
            one.out_color = clr_color;
            batch.push_back(one);
            if (cur_row >= GLYPH_ROWS_DEF)
               cur_row = cur_row - ROW_W'(GLYPH_ROWS_DEF);
            else
               cur_row = '0;
         end
         // one row write per glyph row, empty rows included; code wraps on glyph count
         if (rq.character != NEWLINE_CODE) begin
            for (r = 0; r < GLYPH_ROWS_DEF; r++) begin
               span = (64'(cur_row) + 64'(r)) * 64'(scr_stride) + 64'(cur_col);
               one = '0;
               one.kind = KIND_ROW;
               one.pixel_index = span[IDX_W-1:0];
               one.row_mask = font_copy[{rq.character, 4'(r)}];
               one.out_color = rq.ink_color;
               batch.push_back(one);
            end
         end
         // advance the cursor, wrap on newline or at the right edge
         cur_col = cur_col + COL_W'(GLYPH_WIDTH);
         if (32'(cur_col) + GLYPH_WIDTH + 1 > 32'(scr_width) ||
             rq.character == NEWLINE_CODE) begin
            cur_col = '0;
            cur_row = cur_row + ROW_W'(GLYPH_ROWS_DEF);
         end
         if (batch.size() != 0) begin
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) due_pixel_ops.push_back(batch[i]);
         end
      end
   endtask

   task automatic apply_csr(csr_index_type idx, logic [COLOR_W-1:0] data);
      case (idx)
         CSR_WIDTH:  scr_width  = data[DIM_W-1:0];
         CSR_HEIGHT: scr_height = data[DIM_W-1:0];
         CSR_STRIDE: scr_stride = data[DIM_W-1:0];
         CSR_CLEAR:  clr_color  = data;
         default: ;
      endcase
   endtask

   task automatic check_pixel_op();
      pixel_op_t want;
      if (due_pixel_ops.size() == 0) begin
         flag_mismatch($sformatf("result beat with nothing pending (kind %0d idx %0h)",
                                 rsp_kind, rsp_pixel_index));
      end else begin
         want = due_pixel_ops.pop_front();
         if (rsp_kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d expected %0d", rsp_kind, want.kind));
         if (rsp_pixel_index !== want.pixel_index)
            flag_mismatch($sformatf("pixel_index got %0h expected %0h",
                                    rsp_pixel_index, want.pixel_index));
         if (rsp_row_mask !== want.row_mask)
            flag_mismatch($sformatf("row_mask got %0h expected %0h",
                                    rsp_row_mask, want.row_mask));
         if (rsp_out_color !== want.out_color)
            flag_mismatch($sformatf("out_color got %0h expected %0h",
                                    rsp_out_color, want.out_color));
         if (rsp_last !== want.last)
            flag_mismatch($sformatf("last got %0d expected %0d", rsp_last, want.last));
      end
   endtask

   // Sample every handshake at the rising edge: predict, then check
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      rsp_took = !reset && rsp_valid && rsp_ready;
      if (!reset && csr_valid && csr_ready)
         apply_csr(csr_index_type'(csr_index), csr_wdata);
      if (req_took)
         render_request(req_payload);
      if (rsp_took)
         check_pixel_op();
   end

   // Request driver: hold the offered beat, idle a random gap, then offer the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (req_took) begin
            if ($urandom_range(0, 15) == 0) req_eager = !req_eager;
            req_gap = req_eager ? 0 : $urandom_range(0, 10);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_payload <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall after each beat, forced off during hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 15) == 0) rsp_eager = !rsp_eager;
            rsp_wait = rsp_eager ? 0 : $urandom_range(0, 10);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ready <= !rsp_hold && rsp_wait == 0;
      end
   end

   // Long receiver hold-off so the core backs up and stalls its request side
   initial begin
      wait (backpressure_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic queue_load(logic [GADDR_W-1:0] addr, logic [BYTE_W-1:0] bits);
      console_req_t      rq;
      logic [CHAR_W-1:0] ch;
      bit                full;
      int                k;
      rq.action = ACT_LOAD;
      rq.glyph_addr = addr;
      rq.glyph_byte = bits;
      rq.character = CHAR_W'($urandom);
      rq.ink_color = $urandom;
      req_backlog.push_back(rq);
      row_written[addr] = 1'b1;
      // a glyph becomes printable once all its rows are written
      ch = addr[GADDR_W-1:4];
      full = 1'b1;
      for (k = 0; k < GLYPH_ROWS_DEF; k++)
         if (!row_written[{ch, 4'(k)}]) full = 1'b0;
      if (full && !char_usable[ch]) begin
         char_usable[ch] = 1'b1;
         usable_chars.push_back(ch);
      end
   endtask

   task automatic queue_print(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] ink);
      console_req_t rq;
      rq.action = ACT_PRINT;
      rq.glyph_addr = GADDR_W'($urandom);
      rq.glyph_byte = BYTE_W'($urandom);
      rq.character = ch;
      rq.ink_color = ink;
      req_backlog.push_back(rq);
   endtask

   // Mostly prints of loaded glyphs, plus glyph loads, newlines and stray loads
   task automatic queue_random_traffic(int actions);
      int                n;
      int                pick;
      int                row;
      logic [CHAR_W-1:0] ch;
      for (n = 0; n < actions; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            ch = CHAR_W'($urandom);
            for (row = 0; row < GLYPH_ROWS_DEF; row++)
               queue_load({ch, 4'(row)},
                          ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom));
         end else if (pick < 20) begin
            ch = usable_chars[$urandom_range(0, usable_chars.size() - 1)];
            queue_load({ch, 4'($urandom_range(0, GLYPH_ROWS_DEF - 1))}, BYTE_W'($urandom));
         end else if (pick < 25) begin
            queue_load(GADDR_W'($urandom), BYTE_W'($urandom));
         end else if (pick < 35) begin
            queue_print(NEWLINE_CODE, $urandom);
         end else begin
            ch = usable_chars[$urandom_range(0, usable_chars.size() - 1)];
            queue_print(ch, $urandom);
         end
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [COLOR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and every result has come back, then drain
   task automatic settle();
      int guard;
      for (guard = 0; guard < SETTLE_CAP &&
           (req_backlog.size() != 0 || req_valid || due_pixel_ops.size() != 0); guard++)
         @(posedge clock);
      if (due_pixel_ops.size() != 0) begin
         flag_mismatch($sformatf("%0d expected results never arrived",
                                 due_pixel_ops.size()));
         due_pixel_ops.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   logic [COLOR_W-1:0] ph_width  [PHASES] = '{1024, 16, 0, 4096, 64, 0, 24};
   logic [COLOR_W-1:0] ph_height [PHASES] = '{768, 16, 8, 4096, 80, 0, 48};
   logic [COLOR_W-1:0] ph_stride [PHASES] = '{1024, 16, 4096, 4096, 640, 0, 24};
   logic [COLOR_W-1:0] ph_clear  [PHASES] = '{0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0};

   initial begin
      int p;
      int i;
      ph_width[5]  = $urandom_range(16, 4096);
      ph_height[5] = $urandom_range(16, 4096);
      ph_stride[5] = $urandom_range(16, 4096);
      for (p = 1; p < PHASES; p++)
         if (p != 3) ph_clear[p] = $urandom;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one fully loaded glyph with empty, full and edge rows
      for (i = 0; i < GLYPH_ROWS_DEF; i++)
         queue_load({8'hFF, 4'(i)}, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF :
                                    (i == 2) ? 8'h80 : (i == 3) ? 8'h01 : BYTE_W'($urandom));
      queue_load('0, 8'hA5);
      queue_print(8'hFF, 32'hFFFF_FFFF);
      queue_print(8'hFF, 32'h0000_0000);
      queue_print(NEWLINE_CODE, $urandom);
      queue_print(NEWLINE_CODE, $urandom);
      queue_print(8'hFF, $urandom);

      // Phase 0 runs on reset settings; later ones reprogram every register
      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            write_reg(CSR_WIDTH,  ph_width[p]);
            write_reg(CSR_HEIGHT, ph_height[p]);
            write_reg(CSR_STRIDE, ph_stride[p]);
            write_reg(CSR_CLEAR,  ph_clear[p]);
         end
         if (p == PRESSURE_PH) backpressure_go = 1'b1;
         queue_random_traffic(25);
      end

      settle();
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
